### hdl/brt_pkg.sv
// ----------------------------------------------------------------------------
// brt_pkg
// Shared widths, constants and request codes of the byte rate throttle.
// ----------------------------------------------------------------------------
package brt_pkg;

  localparam int NOW_W     = 48;
  localparam int BYTES_W   = 32;
  localparam int STATE_W   = 2;
  localparam int CREDIT_W  = 42;
  localparam int DELAY_W   = 42;
  localparam int MS_W      = 10;
  localparam int DIVD_W    = 43;
  localparam int DIVS_W    = 32;
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 80;

  localparam logic [BYTES_W-1:0]  RATE_RESET  = 32'd1048576;
  localparam logic [MS_W-1:0]     MS_PER_SEC  = 10'd1000;
  localparam logic [CREDIT_W-1:0] CREDIT_MAX  = {1'b0, {(CREDIT_W-1){1'b1}}};
  localparam logic [DELAY_W-1:0]  DELAY_MAX   = {DELAY_W{1'b1}};

  localparam logic [1:0] REQ_OPEN  = 2'd0;
  localparam logic [1:0] REQ_SEND  = 2'd1;
  localparam logic [1:0] REQ_RETRY = 2'd2;

endpackage

### hdl/brt_div.sv
// ----------------------------------------------------------------------------
// brt_div
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module brt_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [brt_pkg::DIVD_W-1:0]  dividend,
  input  logic [brt_pkg::DIVS_W-1:0]  divisor,
  output logic                        done,
  output logic [brt_pkg::DIVD_W-1:0]  quotient
);

  localparam int CNT_W = $clog2(brt_pkg::DIVD_W + 1);

  logic [brt_pkg::DIVD_W-1:0] quo_r, quo_nxt;
  logic [brt_pkg::DIVS_W-1:0] rem_r, rem_nxt;
  logic [brt_pkg::DIVS_W-1:0] dsr_r, dsr_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [brt_pkg::DIVS_W:0]   shifted;
  logic [brt_pkg::DIVS_W:0]   diff;
  logic                       fits;

  assign shifted = {rem_r, quo_r[brt_pkg::DIVD_W-1]};
  assign diff    = shifted - {1'b0, dsr_r};
  assign fits    = shifted >= {1'b0, dsr_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      cnt_nxt  = CNT_W'(brt_pkg::DIVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[brt_pkg::DIVS_W-1:0] : shifted[brt_pkg::DIVS_W-1:0];
      quo_nxt = {quo_r[brt_pkg::DIVD_W-2:0], fits};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### hdl/byte_rate_throttle.sv
// ----------------------------------------------------------------------------
// byte_rate_throttle
// Byte-rate shaper that keeps a signed credit window and releases stored sends.
// ----------------------------------------------------------------------------
// An open, an unknown request or a release without refill division needs no
// division; a refill within one second of the last one and a held word's delay
// each add one pass of the shared 43-bit divider, and the input is not ready
// while a word is in work.
module byte_rate_throttle (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [brt_pkg::BYTES_W-1:0]         cfg_wr_data,   // rate_bytes_per_sec
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // now_ms [47:0], send_bytes [79:48], send_state [81:80]
  input  logic [brt_pkg::IN_DATA_W-1:0]       in_tdata,
  // req_type [1:0]
  input  logic [1:0]                          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // delay_ms [41:0], released_bytes [73:42], released_state [75:74]
  output logic [brt_pkg::OUT_DATA_W-1:0]      out_tdata,
  // released [0]
  output logic                                out_tuser
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_REFILL, ST_REFILL_WAIT, ST_CHECK, ST_DELAY_WAIT, ST_OUT
  } state_t;

  state_t                              state_r, state_nxt;
  logic [brt_pkg::BYTES_W-1:0]         rate_r, rate_nxt;
  logic [brt_pkg::NOW_W-1:0]           window_r, window_nxt;
  logic [brt_pkg::CREDIT_W-1:0]        credit_r, credit_nxt;
  logic [brt_pkg::BYTES_W-1:0]         pend_bytes_r, pend_bytes_nxt;
  logic [brt_pkg::STATE_W-1:0]         pend_state_r, pend_state_nxt;
  logic [brt_pkg::NOW_W-1:0]           now_r, now_nxt;
  logic                                res_rel_r, res_rel_nxt;
  logic [brt_pkg::DELAY_W-1:0]         res_delay_r, res_delay_nxt;
  logic [brt_pkg::BYTES_W-1:0]         res_bytes_r, res_bytes_nxt;
  logic [brt_pkg::STATE_W-1:0]         res_state_r, res_state_nxt;
  logic                                out_tvalid_r, out_tvalid_nxt;
  logic [brt_pkg::OUT_DATA_W-1:0]      out_tdata_r, out_tdata_nxt;
  logic                                out_tuser_r, out_tuser_nxt;

  logic [brt_pkg::BYTES_W-1:0]         rate_eff;
  logic [brt_pkg::NOW_W-1:0]           elapsed;
  logic                                time_moved;
  logic                                elapsed_long;
  logic [brt_pkg::CREDIT_W-1:0]        deficit;
  logic [brt_pkg::BYTES_W-1:0]         mul_a;
  logic [brt_pkg::MS_W-1:0]            mul_b;
  logic [brt_pkg::CREDIT_W-1:0]        product;
  logic [brt_pkg::BYTES_W-1:0]         add_val;
  logic [brt_pkg::CREDIT_W:0]          sum;
  logic [brt_pkg::CREDIT_W-1:0]        credit_sat;
  logic                                div_start;
  logic [brt_pkg::DIVD_W-1:0]          div_dividend;
  logic [brt_pkg::DIVS_W-1:0]          div_divisor;
  logic                                div_done;
  logic [brt_pkg::DIVD_W-1:0]          div_quo;
  logic                                in_acc;

  assign rate_eff     = (rate_r == '0) ? brt_pkg::BYTES_W'(1) : rate_r;
  assign elapsed      = now_r - window_r;
  assign time_moved   = window_r < now_r;
  assign elapsed_long = elapsed >= brt_pkg::NOW_W'(brt_pkg::MS_PER_SEC);
  assign deficit      = brt_pkg::CREDIT_W'(0) - credit_r;

  // One multiplier serves the refill and the delay numerator.
  assign mul_a   = (state_r == ST_CHECK) ? deficit[brt_pkg::BYTES_W-1:0] : rate_eff;
  assign mul_b   = (state_r == ST_CHECK) ? brt_pkg::MS_PER_SEC : elapsed[brt_pkg::MS_W-1:0];
  assign product = brt_pkg::CREDIT_W'(mul_a) * brt_pkg::CREDIT_W'(mul_b);

  assign div_dividend = (state_r == ST_CHECK)
                      ? ({1'b0, product} + brt_pkg::DIVD_W'(rate_eff - brt_pkg::BYTES_W'(1)))
                      : {1'b0, product};
  assign div_divisor  = (state_r == ST_CHECK) ? rate_eff
                                              : brt_pkg::DIVS_W'(brt_pkg::MS_PER_SEC);
  assign div_start    = ((state_r == ST_REFILL) && time_moved && !elapsed_long) ||
                        ((state_r == ST_CHECK) && credit_r[brt_pkg::CREDIT_W-1]);

  assign add_val    = (state_r == ST_REFILL) ? rate_eff : div_quo[brt_pkg::BYTES_W-1:0];
  assign sum        = {credit_r[brt_pkg::CREDIT_W-1], credit_r} +
                      (brt_pkg::CREDIT_W+1)'(add_val);
  assign credit_sat = (!sum[brt_pkg::CREDIT_W] && sum[brt_pkg::CREDIT_W-1])
                    ? brt_pkg::CREDIT_MAX : sum[brt_pkg::CREDIT_W-1:0];

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  brt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    state_nxt      = state_r;
    rate_nxt       = cfg_wr_en ? cfg_wr_data : rate_r;
    window_nxt     = window_r;
    credit_nxt     = credit_r;
    pend_bytes_nxt = pend_bytes_r;
    pend_state_nxt = pend_state_r;
    now_nxt        = now_r;
    res_rel_nxt    = res_rel_r;
    res_delay_nxt  = res_delay_r;
    res_bytes_nxt  = res_bytes_r;
    res_state_nxt  = res_state_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          now_nxt       = in_tdata[brt_pkg::NOW_W-1:0];
          res_rel_nxt   = 1'b0;
          res_delay_nxt = '0;
          res_bytes_nxt = '0;
          res_state_nxt = '0;
          unique case (in_tuser)
            brt_pkg::REQ_OPEN: begin
              window_nxt     = in_tdata[brt_pkg::NOW_W-1:0];
              credit_nxt     = '0;
              pend_bytes_nxt = '0;
              pend_state_nxt = '0;
              state_nxt      = ST_OUT;
            end
            brt_pkg::REQ_SEND: begin
              pend_bytes_nxt = in_tdata[79:48];
              pend_state_nxt = in_tdata[81:80];
              state_nxt      = ST_REFILL;
            end
            brt_pkg::REQ_RETRY: begin
              state_nxt = ST_REFILL;
            end
            default: begin
              state_nxt = ST_OUT;
            end
          endcase
        end
      end
      ST_REFILL: begin
        if (!time_moved) begin
          state_nxt = ST_CHECK;
        end else if (elapsed_long) begin
          credit_nxt = credit_sat;
          window_nxt = now_r;
          state_nxt  = ST_CHECK;
        end else begin
          state_nxt = ST_REFILL_WAIT;
        end
      end
      ST_REFILL_WAIT: begin
        if (div_done) begin
          credit_nxt = credit_sat;
          window_nxt = now_r;
          state_nxt  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (credit_r[brt_pkg::CREDIT_W-1]) begin
          state_nxt = ST_DELAY_WAIT;
        end else begin
          credit_nxt    = credit_r - brt_pkg::CREDIT_W'(pend_bytes_r);
          res_rel_nxt   = 1'b1;
          res_bytes_nxt = pend_bytes_r;
          res_state_nxt = pend_state_r;
          state_nxt     = ST_OUT;
        end
      end
      ST_DELAY_WAIT: begin
        if (div_done) begin
          res_delay_nxt = div_quo[brt_pkg::DIVD_W-1] ? brt_pkg::DELAY_MAX
                                                     : div_quo[brt_pkg::DELAY_W-1:0];
          state_nxt     = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tuser_nxt  = res_rel_r;
          out_tdata_nxt  = {4'b0, res_state_r, res_bytes_r, res_delay_r};
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rate_r       <= brt_pkg::RATE_RESET;
      window_r     <= '0;
      credit_r     <= '0;
      pend_bytes_r <= '0;
      pend_state_r <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rate_r       <= rate_nxt;
      window_r     <= window_nxt;
      credit_r     <= credit_nxt;
      pend_bytes_r <= pend_bytes_nxt;
      pend_state_r <= pend_state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    now_r       <= now_nxt;
    res_rel_r   <= res_rel_nxt;
    res_delay_r <= res_delay_nxt;
    res_bytes_r <= res_bytes_nxt;
    res_state_r <= res_state_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

`ifndef SYNTH
  // A negative credit never falls below minus the largest byte total.
  a_credit_floor: assert property (@(posedge clk) disable iff (!rst_n)
    credit_r[brt_pkg::CREDIT_W-1] |-> (&credit_r[brt_pkg::CREDIT_W-1:brt_pkg::BYTES_W]))
    else $error("credit below the deficit floor");

  // The divider only finishes while the sequencer waits for it.
  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_REFILL_WAIT || state_r == ST_DELAY_WAIT))
    else $error("divider finished outside a wait state");

  // A released word carries no delay, a held word carries no bytes.
  a_out_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser ? (out_tdata[41:0] == '0)
                              : (out_tdata[75:42] == '0)))
    else $error("inconsistent result word");

  // An accepted word is never followed by another accept in the next cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("input accepted while busy");
`endif

endmodule

### dv/byte_rate_throttle_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// byte_rate_throttle_tb
// Self-checking bench for the byte rate throttle. A short table of opens,
// sends, retries and unknown requests at the field extremes is followed by
// random traffic at several rates, zero and the maximum among them. Every
// word is checked against its fixed table result or the bench's behavioral
// token bucket, with random gaps on both streams and one long output stall.
// ----------------------------------------------------------------------------
module byte_rate_throttle_tb;
  import brt_pkg::*;

  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam logic [1:0] ST_PROGRESS = 2'd0;
  localparam logic [1:0] ST_FINAL    = 2'd1;
  localparam logic [1:0] ST_ERROR    = 2'd2;
  localparam logic [1:0] ST_THREE    = 2'd3;
  localparam logic [NOW_W-1:0] NOW_MAX = '1;
  localparam int N_PHASES = 6;
  localparam int N_ROWS   = 15;

  typedef struct packed {
    logic               rel;
    logic [DELAY_W-1:0] delay;
    logic [BYTES_W-1:0] nbytes;
    logic [STATE_W-1:0] st;
  } result_t;

  typedef struct packed {
    logic [1:0]         req;
    logic [NOW_W-1:0]   now;
    logic [BYTES_W-1:0] nbytes;
    logic [STATE_W-1:0] st;
    logic               typed;
    result_t            res;
  } row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [BYTES_W-1:0]    cfg_wr_data;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [1:0]            in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  logic [BYTES_W-1:0] rate_reg   = RATE_RESET;
  logic [NOW_W-1:0]   win_ms     = '0;
  longint             credit     = 0;
  logic [BYTES_W-1:0] hold_bytes = '0;
  logic [STATE_W-1:0] hold_state = ST_PROGRESS;

  result_t due_results[$];
  int      mismatches   = 0;
  int      words_seen   = 0;
  int      n_released   = 0;
  int      n_held       = 0;
  int      ceiling_hits = 0;
  longint unsigned longest_delay = 0;
  bit      tx_steady    = 0;
  bit      rx_steady    = 0;
  int      hold_asks    = 0;

  byte_rate_throttle dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic result_t throttle_step(logic [1:0] req, logic [NOW_W-1:0] now,
                                            logic [BYTES_W-1:0] nb, logic [STATE_W-1:0] st);
    result_t         res;
    longint unsigned eff;
    longint unsigned span;
    longint unsigned gain;
    longint unsigned owed;
    longint unsigned wait_ms;
    res = '0;
    eff = (rate_reg == '0) ? 64'd1 : 64'(rate_reg);
    if (req == REQ_OPEN) begin
      win_ms     = now;
      credit     = 0;
      hold_bytes = '0;
      hold_state = ST_PROGRESS;
    end else if (req == REQ_SEND || req == REQ_RETRY) begin
      if (req == REQ_SEND) begin
        hold_bytes = nb;
        hold_state = st;
      end
      if (win_ms < now) begin
        span = 64'(now) - 64'(win_ms);
        gain = (span >= 64'(MS_PER_SEC)) ? eff : (eff * span) / 64'(MS_PER_SEC);
        credit += longint'(gain);
        if (credit > longint'(CREDIT_MAX)) begin
          credit = longint'(CREDIT_MAX);
          ceiling_hits++;
        end
        win_ms = now;
      end
      if (credit < 0) begin
        owed    = longint'(-credit);
        wait_ms = (owed * 64'(MS_PER_SEC) + eff - 64'd1) / eff;
        if (wait_ms > 64'(DELAY_MAX))
          wait_ms = 64'(DELAY_MAX);
        res.delay = wait_ms[DELAY_W-1:0];
      end else begin
        credit    -= longint'(hold_bytes);
        res.rel    = 1'b1;
        res.nbytes = hold_bytes;
        res.st     = hold_state;
      end
    end
    return res;
  endfunction

  task automatic put_word(input logic [1:0] req, input logic [NOW_W-1:0] now,
                          input logic [BYTES_W-1:0] nb, input logic [STATE_W-1:0] st,
                          input logic typed, input result_t typed_res);
    result_t want;
    int      gap;
    int      r;
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {{(IN_DATA_W-NOW_W-BYTES_W-STATE_W){1'b0}}, st, nb, now};
    do @(posedge clk); while (!in_tready);
    want = throttle_step(req, now, nb, st);
    due_results.push_back(typed ? typed_res : want);
    r = $urandom_range(0, 99);
    if (tx_steady || r < 55)
      gap = 0;
    else if (r < 90)
      gap = $urandom_range(1, 3);
    else if (r < 98)
      gap = $urandom_range(4, 20);
    else
      gap = $urandom_range(30, 150);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      words_seen++;
      if (due_results.size() == 0) begin
        $error("unexpected result word: released %0b delay_ms %0d", out_tuser,
               out_tdata[DELAY_W-1:0]);
        mismatches++;
      end else begin
        want = due_results.pop_front();
        if (out_tuser !== want.rel) begin
          $error("released: expected %0b, got %0b", want.rel, out_tuser);
          mismatches++;
        end
        if (out_tdata[DELAY_W-1:0] !== want.delay) begin
          $error("delay_ms: expected %0d, got %0d", want.delay, out_tdata[DELAY_W-1:0]);
          mismatches++;
        end
        if (out_tdata[73:42] !== want.nbytes) begin
          $error("released_bytes: expected %0d, got %0d", want.nbytes, out_tdata[73:42]);
          mismatches++;
        end
        if (out_tdata[75:74] !== want.st) begin
          $error("released_state: expected %0d, got %0d", want.st, out_tdata[75:74]);
          mismatches++;
        end
        if (want.rel)
          n_released++;
        else
          n_held++;
        if (64'(want.delay) > longest_delay)
          longest_delay = 64'(want.delay);
      end
    end
  end

  initial begin : drain_side
    int r;
    int n;
    int holds_done;
    holds_done = 0;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_asks != holds_done) begin
        holds_done++;
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if (rx_steady) begin
        out_tready <= 1'b1;
        @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_tready <= 1'b1;
          n = $urandom_range(1, 12);
        end else if (r < 95) begin
          out_tready <= 1'b0;
          n = $urandom_range(1, 4);
        end else begin
          out_tready <= 1'b0;
          n = $urandom_range(20, 100);
        end
        repeat (n) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    #25_000_000;
    $display("byte_rate_throttle regression: fail");
    $finish;
  end

  initial begin : stimulus
    row_t               rows[N_ROWS];
    logic [BYTES_W-1:0] phase_rate[N_PHASES];
    int                 phase_len[N_PHASES];
    bit                 phase_fill[N_PHASES];
    logic [NOW_W-1:0]   cur_ms;
    logic [NOW_W-1:0]   now;
    logic [1:0]         req;
    logic [STATE_W-1:0] st;
    logic [BYTES_W-1:0] nb;
    logic [31:0]        hi;
    longint unsigned    step;
    longint unsigned    eff;
    int                 p;
    int                 i;
    int                 r;

    rows[0]  = '{REQ_RETRY,   48'd0,   32'd0,          ST_PROGRESS, 1'b1,
                 '{1'b1, 42'd0, 32'd0, ST_PROGRESS}};
    rows[1]  = '{REQ_UNKNOWN, 48'h123, 32'hFFFF_FFFF,  ST_THREE,    1'b1, '0};
    rows[2]  = '{REQ_OPEN,    48'd100, 32'd0,          ST_PROGRESS, 1'b1, '0};
    rows[3]  = '{REQ_SEND,    48'd100, 32'd1000,       ST_PROGRESS, 1'b1,
                 '{1'b1, 42'd0, 32'd1000, ST_PROGRESS}};
    rows[4]  = '{REQ_RETRY,   48'd100, 32'd0,          ST_PROGRESS, 1'b0, '0};
    rows[5]  = '{REQ_RETRY,   48'd101, 32'd0,          ST_PROGRESS, 1'b0, '0};
    rows[6]  = '{REQ_SEND,    48'd101, 32'hFFFF_FFFF,  ST_THREE,    1'b0, '0};
    rows[7]  = '{REQ_RETRY,   48'd102, 32'd0,          ST_PROGRESS, 1'b0, '0};
    rows[8]  = '{REQ_RETRY,   48'd5000, 32'd0,         ST_PROGRESS, 1'b0, '0};
    rows[9]  = '{REQ_SEND,    NOW_MAX, 32'd0,          ST_ERROR,    1'b0, '0};
    rows[10] = '{REQ_SEND,    NOW_MAX, 32'd7,          ST_FINAL,    1'b0, '0};
    rows[11] = '{REQ_UNKNOWN, 48'd0,   32'd0,          ST_PROGRESS, 1'b1, '0};
    rows[12] = '{REQ_OPEN,    NOW_MAX, 32'hFFFF_FFFF,  ST_THREE,    1'b1, '0};
    rows[13] = '{REQ_OPEN,    48'd0,   32'd0,          ST_PROGRESS, 1'b1, '0};
    rows[14] = '{REQ_SEND,    48'd0,   32'd0,          ST_FINAL,    1'b1,
                 '{1'b1, 42'd0, 32'd0, ST_FINAL}};

    phase_rate[0] = RATE_RESET;    phase_len[0] = 140; phase_fill[0] = 1'b0;
    phase_rate[1] = 32'd1;         phase_len[1] = 90;  phase_fill[1] = 1'b0;
    phase_rate[2] = 32'd0;         phase_len[2] = 50;  phase_fill[2] = 1'b0;
    phase_rate[3] = 32'hFFFF_FFFF; phase_len[3] = 560; phase_fill[3] = 1'b1;
    phase_rate[4] = 32'd1000;      phase_len[4] = 90;  phase_fill[4] = 1'b0;
    phase_rate[5] = $urandom;      phase_len[5] = 100; phase_fill[5] = 1'b0;

    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = REQ_OPEN;
    cur_ms      = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (p = 0; p < N_PHASES; p++) begin
      if (p > 0) begin
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= phase_rate[p];
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        rate_reg   = phase_rate[p];
        @(posedge clk);
      end else begin
        for (i = 0; i < N_ROWS; i++)
          put_word(rows[i].req, rows[i].now, rows[i].nbytes, rows[i].st, rows[i].typed,
                   rows[i].res);
      end
      eff = (rate_reg == '0) ? 64'd1 : 64'(rate_reg);
      for (i = 0; i < phase_len[p]; i++) begin
        if (i % 50 == 0) begin
          tx_steady = ($urandom_range(0, 3) == 0);
          rx_steady = ($urandom_range(0, 3) == 0);
        end
        if (p == 1 && i == 20) begin
          rx_steady = 1'b0;
          hold_asks++;
        end
        if (p == 5 && i == 50) begin
          in_tvalid <= 1'b0;
          do @(posedge clk); while (due_results.size() != 0);
        end
        r  = $urandom_range(0, 99);
        st = STATE_W'($urandom_range(0, 3));
        if (phase_fill[p]) begin
          step = $urandom_range(1000, 5000);
        end else begin
          case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5:            step = $urandom_range(0, 5);
            16, 17, 18:                  step = $urandom_range(1000, 3000);
            19:                          step = $urandom_range(0, 100000);
            default:                     step = $urandom_range(1, 999);
          endcase
        end
        if (64'(cur_ms) > 64'(NOW_MAX) - step)
          cur_ms = NOW_MAX;
        else
          cur_ms = cur_ms + NOW_W'(step);
        now = cur_ms;
        if (phase_fill[p]) begin
          req = (r < 60) ? REQ_SEND : REQ_RETRY;
          nb  = (r % 10 < 9) ? 32'($urandom_range(0, 255)) : 32'($urandom);
        end else begin
          case ($urandom_range(0, 13))
            0, 1, 2, 3:   nb = $urandom_range(0, 32'(eff >> 2));
            4, 5, 6:      nb = $urandom_range(0, 4095);
            7, 8, 9, 10:  nb = $urandom;
            11:           nb = 32'd0;
            default:      nb = 32'hFFFF_FFFF;
          endcase
          hi = $urandom;
          if (r < 45) begin
            req = REQ_SEND;
          end else if (r < 80) begin
            req = REQ_RETRY;
          end else if (r < 88) begin
            req = REQ_OPEN;
          end else if (r < 92) begin
            req = REQ_UNKNOWN;
            now = {hi[15:0], 32'($urandom)};
          end else if (r < 96) begin
            req    = REQ_OPEN;
            now    = {hi[15:0], 32'($urandom)};
            cur_ms = now;
          end else begin
            req  = hi[20] ? REQ_SEND : REQ_RETRY;
            step = $urandom_range(0, 2000);
            now  = (64'(cur_ms) > step) ? cur_ms - NOW_W'(step) : '0;
          end
        end
        put_word(req, now, nb, st, 1'b0, '0);
      end
      in_tvalid <= 1'b0;
      rx_steady  = 1'b0;
      do @(posedge clk); while (due_results.size() != 0);
      repeat (4) @(posedge clk);
    end

    repeat (120) @(posedge clk);
    $display("Covered %0d words at %0d rate settings including zero and full scale.",
             words_seen, N_PHASES);
    $display("%0d released, %0d held back (longest delay %0d ms), credit ceiling hit %0d times.",
             n_released, n_held, longest_delay, ceiling_hits);
    if (mismatches == 0 && due_results.size() == 0)
      $display("byte_rate_throttle regression: pass");
    else
      $display("byte_rate_throttle regression: fail");
    $finish;
  end

endmodule

### files.f
hdl/brt_pkg.sv
hdl/brt_div.sv
hdl/byte_rate_throttle.sv
dv/byte_rate_throttle_tb.sv
